/* rtl/trle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types, codes and the effect classifier for the pattern event
// run-length decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int unsigned FLAG_W    = 29;
  localparam int unsigned ROW_OUT_W = 6;
  localparam int unsigned CNT_W     = 7;

  localparam logic [7:0]       RUN_MARK = 8'hFC;
  localparam logic [CNT_W-1:0] MAX_EMIT = 7'd64;

  // last byte position of each record kind
  localparam logic [2:0] POS_PLAIN_LAST = 3'd4;
  localparam logic [2:0] POS_RUN_LAST   = 3'd6;

  // effect codes
  localparam logic [3:0] FX_ARP       = 4'h0;
  localparam logic [3:0] FX_PORTA_UP  = 4'h1;
  localparam logic [3:0] FX_PORTA_DN  = 4'h2;
  localparam logic [3:0] FX_TONE_PORT = 4'h3;
  localparam logic [3:0] FX_VIB       = 4'h4;
  localparam logic [3:0] FX_LOOP_CTL  = 4'h5;
  localparam logic [3:0] FX_SIX       = 4'h6;
  localparam logic [3:0] FX_TREM      = 4'h7;
  localparam logic [3:0] FX_EIGHT     = 4'h8;
  localparam logic [3:0] FX_SMP_OFS   = 4'h9;
  localparam logic [3:0] FX_VOL_SLIDE = 4'hA;
  localparam logic [3:0] FX_PAN       = 4'hB;
  localparam logic [3:0] FX_SET_VOL   = 4'hC;
  localparam logic [3:0] FX_PAT_BRK   = 4'hD;
  localparam logic [3:0] FX_EXTENDED  = 4'hE;

  // loop-control sub codes (parameter upper nibble)
  localparam logic [3:0] LOOP_NONE = 4'h1;
  localparam logic [3:0] LOOP_BACK = 4'h2;
  localparam logic [3:0] LOOP_STOP = 4'hC;

  // extended-effect sub codes (parameter upper nibble)
  localparam logic [3:0] EXT_FILTER   = 4'h0;
  localparam logic [3:0] EXT_FINE_UP  = 4'h1;
  localparam logic [3:0] EXT_FINE_DN  = 4'h2;
  localparam logic [3:0] EXT_RETRIG   = 4'h8;
  localparam logic [3:0] EXT_NINE     = 4'h9;
  localparam logic [3:0] EXT_FVOL_UP  = 4'hA;
  localparam logic [3:0] EXT_FVOL_DN  = 4'hB;
  localparam logic [3:0] EXT_CUT      = 4'hC;
  localparam logic [3:0] EXT_DELAY    = 4'hD;

  // feature flag bits
  localparam int unsigned FEAT_ARPEGGIO  = 4;
  localparam int unsigned FEAT_PORTA     = 5;
  localparam int unsigned FEAT_TONE_PORT = 6;
  localparam int unsigned FEAT_VIBRATO   = 7;
  localparam int unsigned FEAT_NO_LOOP   = 8;
  localparam int unsigned FEAT_BACKWARDS = 9;
  localparam int unsigned FEAT_END_LOOP  = 10;
  localparam int unsigned FEAT_SIX       = 12;
  localparam int unsigned FEAT_TREMOLO   = 13;
  localparam int unsigned FEAT_EIGHT     = 14;
  localparam int unsigned FEAT_OFFSET    = 15;
  localparam int unsigned FEAT_FINE_OFS  = 16;
  localparam int unsigned FEAT_VOL_SLIDE = 17;
  localparam int unsigned FEAT_PAN       = 18;
  localparam int unsigned FEAT_VOLUME    = 19;
  localparam int unsigned FEAT_BREAK     = 20;
  localparam int unsigned FEAT_SPEED     = 21;
  localparam int unsigned FEAT_EXT_FILT  = 22;
  localparam int unsigned FEAT_EXT_FINE  = 23;
  localparam int unsigned FEAT_EXT_RETRG = 24;
  localparam int unsigned FEAT_EXT_NINE  = 25;
  localparam int unsigned FEAT_EXT_FVOL  = 26;
  localparam int unsigned FEAT_EXT_CUT   = 27;
  localparam int unsigned FEAT_EXT_DELAY = 28;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } trle_state_t;

  typedef struct packed {
    logic take;  // byte request accepted this cycle
    logic step;  // event request delivered this cycle
  } trle_cmd_t;

  typedef struct packed {
    logic rec_done;    // current input byte completes a record
    logic last_event;  // event on the output is the last of its record
  } trle_sts_t;

  // Feature mask, with at most one bit set, for one effect/parameter pair
  function automatic logic [FLAG_W-1:0] classify(input logic [3:0] fx,
                                                 input logic [7:0] prm);
    logic [FLAG_W-1:0] m;
    m = '0;
    unique case (fx) inside
      FX_ARP:                   m[FEAT_ARPEGGIO] = (prm != 8'd0);
      FX_PORTA_UP, FX_PORTA_DN: m[FEAT_PORTA]     = 1'b1;
      FX_TONE_PORT:             m[FEAT_TONE_PORT] = 1'b1;
      FX_VIB:                   m[FEAT_VIBRATO]   = 1'b1;
      FX_LOOP_CTL: begin
        unique case (prm[7:4])
          LOOP_NONE: m[FEAT_NO_LOOP]   = 1'b1;
          LOOP_BACK: m[FEAT_BACKWARDS] = 1'b1;
          LOOP_STOP: m[FEAT_END_LOOP]  = 1'b1;
          default:   m = '0;
        endcase
      end
      FX_SIX:       m[FEAT_SIX]       = 1'b1;
      FX_TREM:      m[FEAT_TREMOLO]   = 1'b1;
      FX_EIGHT:     m[FEAT_EIGHT]     = 1'b1;
      FX_SMP_OFS:   m[FEAT_OFFSET]    = 1'b1;
      FX_VOL_SLIDE: m[FEAT_VOL_SLIDE] = 1'b1;
      FX_PAN:       m[FEAT_PAN]       = 1'b1;
      FX_SET_VOL:   m[FEAT_VOLUME]    = 1'b1;
      FX_PAT_BRK:   m[FEAT_BREAK]     = 1'b1;
      FX_EXTENDED: begin
        unique case (prm[7:4]) inside
          EXT_FILTER:               m[FEAT_EXT_FILT]  = 1'b1;
          EXT_FINE_UP, EXT_FINE_DN: m[FEAT_EXT_FINE]  = 1'b1;
          EXT_RETRIG:               m[FEAT_EXT_RETRG] = 1'b1;
          EXT_NINE:                 m[FEAT_EXT_NINE]  = 1'b1;
          EXT_FVOL_UP, EXT_FVOL_DN: m[FEAT_EXT_FVOL]  = 1'b1;
          EXT_CUT:                  m[FEAT_EXT_CUT]   = 1'b1;
          EXT_DELAY:                m[FEAT_EXT_DELAY] = 1'b1;
          default:                  m = '0;
        endcase
      end
      default: m[FEAT_SPEED] = 1'b1;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/trle_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trle_in_if / trle_out_if
// Valid/ready channels for raw pattern bytes and decoded events.
// ----------------------------------------------------------------------------
interface trle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       new_file;

  modport source (output valid, output byte_in, output new_file, input ready);
  modport sink   (input valid, input byte_in, input new_file, output ready);
endinterface

interface trle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  note;
  logic [7:0]  sample_num;
  logic [3:0]  effect_hi;
  logic [3:0]  effect_lo;
  logic [7:0]  param_first;
  logic [7:0]  param_second;
  logic [5:0]  row;
  logic        last_of_run;
  logic        end_of_block;
  logic [28:0] uses_mask;

  modport source (output valid, output note, output sample_num, output effect_hi,
                  output effect_lo, output param_first, output param_second,
                  output row, output last_of_run, output end_of_block,
                  output uses_mask, input ready);
  modport sink   (input valid, input note, input sample_num, input effect_hi,
                  input effect_lo, input param_first, input param_second,
                  input row, input last_of_run, input end_of_block,
                  input uses_mask, output ready);
endinterface
`default_nettype wire

/* rtl/trle_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trle_ctrl
// Controller: accepts bytes while idle, then emits the events of a
// completed record one per output request.
// ----------------------------------------------------------------------------
module trle_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  trle_pkg::trle_sts_t sts,
  output trle_pkg::trle_cmd_t cmd
);
  import trle_pkg::*;

  trle_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.rec_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.last_event) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && cmd.step))
    else $error("byte taken while an event is delivered");

  a_done_enters_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && sts.rec_done |=> out_valid && !in_ready)
    else $error("completed record did not start emission");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.last_event |=> in_ready && !out_valid)
    else $error("last event did not release the input");
`endif

endmodule
`default_nettype wire

/* rtl/trle_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trle_dpath
// Datapath: record assembly, feature flags, repeat counter, row counter and
// the event output register.
// ----------------------------------------------------------------------------
module trle_dpath #(
  parameter int unsigned ROWS_PER_BLOCK = 64
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  trle_pkg::trle_cmd_t       cmd,
  output trle_pkg::trle_sts_t       sts,
  input  wire [7:0]                 byte_in,
  input  wire                       new_file,
  output logic [7:0]                note,
  output logic [7:0]                sample_num,
  output logic [3:0]                effect_hi,
  output logic [3:0]                effect_lo,
  output logic [7:0]                param_first,
  output logic [7:0]                param_second,
  output logic [trle_pkg::ROW_OUT_W-1:0] row,
  output logic                      last_of_run,
  output logic                      end_of_block,
  output logic [trle_pkg::FLAG_W-1:0]    uses_mask
);
  import trle_pkg::*;

  localparam int unsigned ROW_W = (ROWS_PER_BLOCK > 1) ? $clog2(ROWS_PER_BLOCK) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS_PER_BLOCK - 1);

  logic [7:0]        rec_r [0:6];
  logic [2:0]        pos_r, pos_nxt, pos_eff;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt, flags_base;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_load;
  logic [7:0]        note_r, smp_r, fx_r, p2_r, p1_r;
  logic [7:0]        fx_sel, p2_sel, cnt_byte;
  logic              is_run, done, row_at_last;
  logic [ROW_W+ROW_OUT_W-1:0] row_ext;

  // the current byte lands at position zero after a file restart
  assign pos_eff = new_file ? 3'd0 : pos_r;
  assign is_run  = (pos_eff == 3'd0) ? (byte_in == RUN_MARK) : (rec_r[0] == RUN_MARK);
  assign done    = is_run ? (pos_eff == POS_RUN_LAST) : (pos_eff == POS_PLAIN_LAST);

  assign fx_sel   = is_run ? rec_r[4] : rec_r[2];
  assign p2_sel   = is_run ? rec_r[5] : rec_r[3];
  assign cnt_byte = is_run ? rec_r[1] : 8'd1;

  // zero counts as one; clip at the per-record emit limit
  always_comb begin
    if (cnt_byte == 8'd0) begin
      cnt_load = CNT_W'(1);
    end else if (cnt_byte > 8'(MAX_EMIT)) begin
      cnt_load = MAX_EMIT;
    end else begin
      cnt_load = cnt_byte[CNT_W-1:0];
    end
  end

  assign flags_base = new_file ? '0 : flags_r;
  assign row_at_last = (row_r == ROW_LAST);

  always_comb begin
    pos_nxt   = pos_r;
    row_nxt   = row_r;
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    if (cmd.take) begin
      pos_nxt = done ? 3'd0 : 3'(pos_eff + 3'd1);
      if (new_file) begin
        row_nxt = '0;
      end
      if (done) begin
        flags_nxt = flags_base | classify(fx_sel[7:4], byte_in)
                  | classify(fx_sel[3:0], p2_sel);
        if (fx_sel[7:4] == FX_SMP_OFS && fx_sel[3:0] == FX_SMP_OFS) begin
          flags_nxt[FEAT_FINE_OFS] = 1'b1;
        end
        cnt_nxt = cnt_load;
      end else begin
        flags_nxt = flags_base;
      end
    end else if (cmd.step) begin
      row_nxt = row_at_last ? '0 : ROW_W'(row_r + ROW_W'(1));
      cnt_nxt = CNT_W'(cnt_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      row_r   <= '0;
      flags_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      row_r   <= row_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (cmd.take) begin
      rec_r[pos_eff] <= byte_in;
    end
    if (cmd.take && done) begin
      note_r <= is_run ? rec_r[2] : rec_r[0];
      smp_r  <= is_run ? rec_r[3] : rec_r[1];
      fx_r   <= fx_sel;
      p2_r   <= p2_sel;
      p1_r   <= byte_in;
    end
  end

  assign row_ext = {ROW_OUT_W'(0), row_r};

  assign sts.rec_done   = done;
  assign sts.last_event = (cnt_r == CNT_W'(1)) || row_at_last;

  assign note         = note_r;
  assign sample_num   = smp_r;
  assign effect_hi    = fx_r[7:4];
  assign effect_lo    = fx_r[3:0];
  assign param_first  = p1_r;
  assign param_second = p2_r;
  assign row          = row_ext[ROW_OUT_W-1:0];
  assign last_of_run  = sts.last_event;
  assign end_of_block = row_at_last;
  assign uses_mask    = flags_r;

`ifndef SYNTHESIS
  a_row_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_LAST)
    else $error("row counter beyond block");

  a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> cnt_r != '0)
    else $error("event emitted with no repeats left");

  a_flags_hold_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> $stable(flags_r))
    else $error("feature flags changed during emission");
`endif

endmodule
`default_nettype wire

/* rtl/tracker_event_rle_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tracker_event_rle_decoder_unit
// Run-length decoder for tracker pattern events: assembles 5-byte plain and
// 7-byte run records and emits one event per repetition with feature flags.
// ----------------------------------------------------------------------------
// Latency: the first event of a record is valid the cycle after its last byte.
// Throughput: one byte per cycle while assembling; the input stalls while the
//   N events of a record are emitted, one per cycle while the output is ready
//   (N is 1 for a plain record, 1 to 64 for a run).
// Reset: synchronous, active low; clears the controller, parser position,
//   row counter and feature flags at once, with no clearing pass.
module tracker_event_rle_decoder_unit #(
  parameter int unsigned ROWS_PER_BLOCK = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  trle_in_if.sink    in_ch,
  trle_out_if.source out_ch
);
  import trle_pkg::*;

  trle_cmd_t cmd;
  trle_sts_t sts;

  trle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trle_dpath #(
    .ROWS_PER_BLOCK (ROWS_PER_BLOCK)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .byte_in      (in_ch.byte_in),
    .new_file     (in_ch.new_file),
    .note         (out_ch.note),
    .sample_num   (out_ch.sample_num),
    .effect_hi    (out_ch.effect_hi),
    .effect_lo    (out_ch.effect_lo),
    .param_first  (out_ch.param_first),
    .param_second (out_ch.param_second),
    .row          (out_ch.row),
    .last_of_run  (out_ch.last_of_run),
    .end_of_block (out_ch.end_of_block),
    .uses_mask    (out_ch.uses_mask)
  );

endmodule
`default_nettype wire

/* bench/tracker_event_rle_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tracker_event_rle_decoder_unit_tb
// Streams plain and run-length pattern records, byte by byte, into the event
// decoder under random source gaps and sink stalls. A local decoder predicts
// every event (rows, run ends, block ends, sticky feature flags), and each
// delivered event is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tracker_event_rle_decoder_unit_tb;
  import trle_pkg::*;

  localparam int unsigned BLOCK_ROWS  = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct {
    logic [7:0]        note;
    logic [7:0]        sample_num;
    logic [3:0]        effect_hi;
    logic [3:0]        effect_lo;
    logic [7:0]        param_first;
    logic [7:0]        param_second;
    logic [5:0]        row;
    logic              last_of_run;
    logic              end_of_block;
    logic [FLAG_W-1:0] uses_mask;
  } pattern_event_t;

  typedef struct {
    logic [7:0] data;
    logic       new_file;
    bit         drain;  // hold this byte until no event is outstanding
  } stream_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  trle_in_if  in_ch ();
  trle_out_if out_ch ();

  tracker_event_rle_decoder_unit #(
    .ROWS_PER_BLOCK(BLOCK_ROWS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  stream_byte_t   stream_bytes[$];
  pattern_event_t expected_events[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned events_seen    = 0;
  bit          byte_taken     = 1'b0;
  logic [3:0]  fx_seq         = 4'h0;

  // decoder state
  logic [7:0]        rec_buf[0:6];
  int unsigned       rec_pos    = 0;
  int unsigned       row_pos    = 0;
  logic [FLAG_W-1:0] feat_flags = '0;

  initial begin
    for (int i = 0; i < 7; i++) rec_buf[3'(i)] = 8'h00;
  end

  // feature flags raised by one effect and its parameter
  function automatic logic [FLAG_W-1:0] effect_features(input logic [3:0] fx,
                                                        input logic [7:0] prm);
    logic [FLAG_W-1:0] m;
    m = '0;
    case (fx)
      FX_ARP:                   m[FEAT_ARPEGGIO]  = (prm != 8'h00);
      FX_PORTA_UP, FX_PORTA_DN: m[FEAT_PORTA]     = 1'b1;
      FX_TONE_PORT:             m[FEAT_TONE_PORT] = 1'b1;
      FX_VIB:                   m[FEAT_VIBRATO]   = 1'b1;
      FX_LOOP_CTL: begin
        if (prm[7:4] == LOOP_NONE)      m[FEAT_NO_LOOP]   = 1'b1;
        else if (prm[7:4] == LOOP_BACK) m[FEAT_BACKWARDS] = 1'b1;
        else if (prm[7:4] == LOOP_STOP) m[FEAT_END_LOOP]  = 1'b1;
      end
      FX_SIX:       m[FEAT_SIX]       = 1'b1;
      FX_TREM:      m[FEAT_TREMOLO]   = 1'b1;
      FX_EIGHT:     m[FEAT_EIGHT]     = 1'b1;
      FX_SMP_OFS:   m[FEAT_OFFSET]    = 1'b1;
      FX_VOL_SLIDE: m[FEAT_VOL_SLIDE] = 1'b1;
      FX_PAN:       m[FEAT_PAN]       = 1'b1;
      FX_SET_VOL:   m[FEAT_VOLUME]    = 1'b1;
      FX_PAT_BRK:   m[FEAT_BREAK]     = 1'b1;
      FX_EXTENDED: begin
        case (prm[7:4])
          EXT_FILTER:               m[FEAT_EXT_FILT]  = 1'b1;
          EXT_FINE_UP, EXT_FINE_DN: m[FEAT_EXT_FINE]  = 1'b1;
          EXT_RETRIG:               m[FEAT_EXT_RETRG] = 1'b1;
          EXT_NINE:                 m[FEAT_EXT_NINE]  = 1'b1;
          EXT_FVOL_UP, EXT_FVOL_DN: m[FEAT_EXT_FVOL]  = 1'b1;
          EXT_CUT:                  m[FEAT_EXT_CUT]   = 1'b1;
          EXT_DELAY:                m[FEAT_EXT_DELAY] = 1'b1;
          default: ;
        endcase
      end
      default: m[FEAT_SPEED] = 1'b1;
    endcase
    return m;
  endfunction

  // take one accepted byte; queue the events of a completed record
  task automatic decode_byte(input logic [7:0] b, input logic nf);
    int unsigned    need, base, reps, room;
    logic [7:0]     fx_b;
    pattern_event_t ev;
    if (nf) begin
      rec_pos    = 0;
      row_pos    = 0;
      feat_flags = '0;
    end
    if (rec_pos > 6) rec_pos = 0;
    rec_buf[3'(rec_pos)] = b;
    rec_pos++;
    need = (rec_buf[0] == RUN_MARK) ? 7 : 5;
    if (rec_pos < need) return;
    rec_pos = 0;

    base = (need == 7) ? 2 : 0;
    reps = (need == 7) ? 32'(rec_buf[1]) : 1;
    if (reps == 0) reps = 1;
    fx_b = rec_buf[3'(base + 2)];

    ev.note         = rec_buf[3'(base)];
    ev.sample_num   = rec_buf[3'(base + 1)];
    ev.effect_hi    = fx_b[7:4];
    ev.effect_lo    = fx_b[3:0];
    ev.param_second = rec_buf[3'(base + 3)];
    ev.param_first  = rec_buf[3'(base + 4)];

    feat_flags |= effect_features(ev.effect_hi, ev.param_first);
    feat_flags |= effect_features(ev.effect_lo, ev.param_second);
    if (ev.effect_hi == FX_SMP_OFS && ev.effect_lo == FX_SMP_OFS)
      feat_flags[FEAT_FINE_OFS] = 1'b1;

    // clip the run at the end of the block and at the per-record cap
    if (row_pos >= BLOCK_ROWS) row_pos = 0;
    room = BLOCK_ROWS - row_pos;
    if (reps > room) reps = room;
    if (reps > int'(MAX_EMIT)) reps = int'(MAX_EMIT);

    for (int unsigned k = 0; k < reps; k++) begin
      ev.row          = 6'(row_pos);
      ev.last_of_run  = (k + 1 == reps);
      ev.end_of_block = (row_pos == BLOCK_ROWS - 1);
      ev.uses_mask    = feat_flags;
      expected_events.push_back(ev);
      row_pos++;
      if (row_pos >= BLOCK_ROWS) row_pos = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("event %0d %s: got %0h, expected %0h",
                                events_seen, name, got, want));
  endtask

  task automatic push_byte(input logic [7:0] b, input logic nf, input bit hold);
    stream_bytes.push_back('{data: b, new_file: nf, drain: hold});
  endtask

  task automatic push_record(input bit is_run, input logic [7:0] cnt,
                             input logic [7:0] note_b, input logic [7:0] smp_b,
                             input logic [7:0] fx_b, input logic [7:0] p2_b,
                             input logic [7:0] p1_b, input logic nf, input bit hold);
    if (is_run) begin
      push_byte(RUN_MARK, nf, hold);
      push_byte(cnt, 1'b0, 1'b0);
      push_byte(note_b, 1'b0, 1'b0);
    end else begin
      push_byte(note_b, nf, hold);
    end
    push_byte(smp_b, 1'b0, 1'b0);
    push_byte(fx_b, 1'b0, 1'b0);
    push_byte(p2_b, 1'b0, 1'b0);
    push_byte(p1_b, 1'b0, 1'b0);
  endtask

  // mostly well-formed records with random content, some stray and cut bytes
  task automatic push_random_traffic(input int n_bytes, input bit first_drain);
    int         pushed, sel, k, nb;
    logic [7:0] note_b, fx_b, cnt_b, p1_b, p2_b;
    bit         nf, hold, resync;
    pushed = 0;
    resync = 1'b0;
    while (pushed < n_bytes) begin
      sel    = $urandom_range(99);
      nf     = resync || ($urandom_range(99) < 4);
      hold   = (first_drain && pushed == 0) || ($urandom_range(99) < 6);
      resync = 1'b0;
      note_b = 8'($urandom);
      p1_b   = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
      p2_b   = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
      // walk the upper effect through every code
      if ($urandom_range(1)) fx_b = {fx_seq, 4'($urandom_range(15))};
      else fx_b = 8'($urandom);
      fx_seq++;
      if (sel < 6) begin
        // stray byte: alignment stays off until a new file restarts it
        push_byte(8'($urandom), nf, hold);
        pushed++;
        resync = 1'($urandom_range(1));
      end else if (sel < 12) begin
        // cut record, restarted by a new file
        nb = $urandom_range(4, 1);
        push_byte(($urandom_range(1) ? RUN_MARK : note_b), nf, hold);
        for (int i = 1; i < nb; i++) push_byte(8'($urandom), 1'b0, 1'b0);
        pushed += nb;
        resync = 1'b1;
      end else if (sel < 58) begin
        if (note_b == RUN_MARK) note_b = 8'hFB;
        push_record(1'b0, 8'h00, note_b, 8'($urandom), fx_b, p2_b, p1_b, nf, hold);
        pushed += 5;
      end else begin
        k = $urandom_range(9);
        if (k < 7)      cnt_b = 8'($urandom_range(6));
        else if (k < 9) cnt_b = 8'($urandom_range(70, 7));
        else            cnt_b = 8'($urandom);
        push_record(1'b1, cnt_b, note_b, 8'($urandom), fx_b, p2_b, p1_b, nf, hold);
        pushed += 7;
      end
    end
  endtask

  // driver and receiver: change inputs at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || byte_taken)) begin
      if (stream_bytes.size() != 0 &&
          !(stream_bytes[0].drain && expected_events.size() != 0) &&
          $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid    <= 1'b1;
        in_ch.byte_in  <= stream_bytes[0].data;
        in_ch.new_file <= stream_bytes[0].new_file;
        void'(stream_bytes.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // predict on accepted bytes, then check delivered events
  always @(posedge clk) begin
    pattern_event_t want;
    byte_taken = rst_n && in_ch.valid && in_ch.ready;
    if (byte_taken) decode_byte(in_ch.byte_in, in_ch.new_file);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("event %0d arrived with none expected", events_seen));
      end else begin
        want = expected_events.pop_front();
        check_field("note", 32'(out_ch.note), 32'(want.note));
        check_field("sample_num", 32'(out_ch.sample_num), 32'(want.sample_num));
        check_field("effect_hi", 32'(out_ch.effect_hi), 32'(want.effect_hi));
        check_field("effect_lo", 32'(out_ch.effect_lo), 32'(want.effect_lo));
        check_field("param_first", 32'(out_ch.param_first), 32'(want.param_first));
        check_field("param_second", 32'(out_ch.param_second), 32'(want.param_second));
        check_field("row", 32'(out_ch.row), 32'(want.row));
        check_field("last_of_run", 32'(out_ch.last_of_run), 32'(want.last_of_run));
        check_field("end_of_block", 32'(out_ch.end_of_block), 32'(want.end_of_block));
        check_field("uses_mask", 32'(out_ch.uses_mask), 32'(want.uses_mask));
      end
      events_seen++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid    = 1'b0;
    in_ch.byte_in  = 8'h00;
    in_ch.new_file = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      if (phase == 0) begin
        // both effects offset, zero parameters
        push_record(1'b0, 8'h00, 8'h00, 8'h00, 8'h99, 8'h00, 8'h00, 1'b1, 1'b0);
        // run count zero emits once; arpeggio with zero parameter sets nothing
        push_record(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h0E, 8'h00, 8'h00, 1'b0, 1'b0);
        // oversized run: clipped at the last row, row counter wraps
        push_record(1'b1, 8'hFF, 8'h12, 8'h34, 8'hF5, 8'hC0, 8'h1A, 1'b0, 1'b0);
        // full block from row zero, at the per-record cap
        push_record(1'b1, 8'h40, RUN_MARK, 8'h80, 8'h5E, 8'hD7, 8'h10, 1'b0, 1'b0);
      end
      push_random_traffic(50, phase == 1);
      while (stream_bytes.size() != 0 || in_ch.valid || expected_events.size() != 0)
        @(negedge clk);
    end

    repeat (8) @(negedge clk);
    if (err_count == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/trle_pkg.sv
rtl/trle_if.sv
rtl/trle_ctrl.sv
rtl/trle_dpath.sv
rtl/tracker_event_rle_decoder_unit.sv
bench/tracker_event_rle_decoder_unit_tb.sv
